[hdl/sqis_pkg.sv]
// ============================================================================
// sqis_pkg : shared types and constants of the shell quartet index sequencer
// Operation codes, field widths, the result bundle and count clamping.
// ============================================================================
package sqis_pkg;

    localparam int MAX_SHELLS          = 256;
    localparam int MAX_PRIMS_PER_SHELL = 16;

    localparam int SHELL_W = 8;
    localparam int CNT_W   = 5;
    localparam int LOC_W   = 4;
    localparam int OFF_W   = 12;
    localparam int SCNT_W  = 9;
    localparam int ADDR_W  = $clog2(MAX_SHELLS);

    localparam logic [SCNT_W-1:0] SHELL_COUNT_RESET = SCNT_W'(1);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_SHELL = 2'd1,
        OP_PRIM  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        REG_SHELL_COUNT = 1'b0
    } t_reg;

    typedef struct packed {
        logic                          more;
        logic [3:0][SHELL_W-1:0]       shell;
        logic [3:0][OFF_W-1:0]         prim;
    } t_result;

    // count minus one, with zero acting as one and the top clamped
    function automatic logic [LOC_W-1:0] cnt_lim(input logic [CNT_W-1:0] c);
        logic [LOC_W-1:0] res;
        if (c == '0) begin
            res = '0;
        end else if (c > CNT_W'(MAX_PRIMS_PER_SHELL)) begin
            res = LOC_W'(MAX_PRIMS_PER_SHELL - 1);
        end else begin
            res = LOC_W'(c - CNT_W'(1));
        end
        return res;
    endfunction

    // index of the last shell in use
    function automatic logic [SHELL_W-1:0] last_shell(input logic [SCNT_W-1:0] n);
        logic [SHELL_W-1:0] res;
        if (n == '0) begin
            res = '0;
        end else if (n > SCNT_W'(MAX_SHELLS)) begin
            res = SHELL_W'(MAX_SHELLS - 1);
        end else begin
            res = SHELL_W'(n - SCNT_W'(1));
        end
        return res;
    endfunction

endpackage

[hdl/sqis_cnt_mem.sv]
// ============================================================================
// sqis_cnt_mem : primitive count store
// One write port and one registered read port, write-first on a match.
// ============================================================================
module sqis_cnt_mem (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [sqis_pkg::ADDR_W-1:0]   i_waddr,
    input  logic [sqis_pkg::CNT_W-1:0]    i_wdata,
    input  logic [sqis_pkg::ADDR_W-1:0]   i_raddr,
    output logic [sqis_pkg::CNT_W-1:0]    o_rdata
);
    import sqis_pkg::*;

    logic [CNT_W-1:0] r_mem [MAX_SHELLS];
    logic [CNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sqis_core.sv]
// ============================================================================
// sqis_core : quartet state and step logic
// Holds shell indices, local primitive indices and offsets, and computes the
// state after one transfer together with the result it reports.
// ============================================================================
module sqis_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  sqis_pkg::t_op                  i_op,
    input  logic [sqis_pkg::SHELL_W-1:0]   i_shell,
    input  logic [sqis_pkg::CNT_W-1:0]     i_prim_count,
    input  logic [sqis_pkg::SHELL_W-1:0]   i_last,
    output sqis_pkg::t_result              o_result
);
    import sqis_pkg::*;

    logic [SHELL_W-1:0] r_shell [4];
    logic [LOC_W-1:0]   r_local [4];
    logic [OFF_W-1:0]   r_off   [4];

    logic [SHELL_W-1:0] n_shell [4];
    logic [LOC_W-1:0]   n_local [4];
    logic [OFF_W-1:0]   n_off   [4];

    logic [SHELL_W-1:0] sh_step [4];
    logic [LOC_W-1:0]   lo_step [4];
    logic [OFF_W-1:0]   of_step [4];

    logic [CNT_W-1:0]   cnt [4];
    logic [LOC_W-1:0]   lim [4];
    logic [ADDR_W-1:0]  rd_addr [4];
    logic               we;

    logic [SHELL_W-1:0] dmax;
    logic [1:0]         s_pos;
    logic               s_wrap;
    logic [1:0]         p_pos;
    logic               p_wrap;
    logic               more;

    assign we = i_accept && (i_op == OP_LOAD);

    for (genvar g = 0; g < 4; g++) begin : g_mem
        assign rd_addr[g] = i_rst_n ? ADDR_W'(n_shell[g]) : '0;
        assign lim[g]     = cnt_lim(cnt[g]);

        sqis_cnt_mem u_mem (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (ADDR_W'(i_shell)),
            .i_wdata (i_prim_count),
            .i_raddr (rd_addr[g]),
            .o_rdata (cnt[g])
        );
    end

    // next shell quartet: pick the position that advances
    always_comb begin
        dmax   = (r_shell[0] == r_shell[1]) ? r_shell[2] : r_shell[1];
        s_pos  = 2'd0;
        s_wrap = 1'b0;
        if (r_shell[3] < dmax) begin
            s_pos = 2'd3;
        end else if (r_shell[2] < r_shell[0]) begin
            s_pos = 2'd2;
        end else if (r_shell[1] < r_shell[0]) begin
            s_pos = 2'd1;
        end else if (r_shell[0] < i_last) begin
            s_pos = 2'd0;
        end else begin
            s_wrap = 1'b1;
        end
        for (int k = 0; k < 4; k++) begin
            sh_step[k] = r_shell[k];
            of_step[k] = r_off[k];
            if (s_wrap || (2'(k) > s_pos)) begin
                sh_step[k] = '0;
                of_step[k] = '0;
            end else if (2'(k) == s_pos) begin
                sh_step[k] = r_shell[k] + SHELL_W'(1);
                of_step[k] = r_off[k] + OFF_W'(lim[k]) + OFF_W'(1);
            end
        end
    end

    // next primitive quartet: odometer with the last position fastest
    always_comb begin
        p_pos  = 2'd0;
        p_wrap = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (r_local[k] < lim[k]) begin
                p_pos  = 2'(k);
                p_wrap = 1'b0;
            end
        end
        for (int k = 0; k < 4; k++) begin
            lo_step[k] = r_local[k];
            if (p_wrap || (2'(k) > p_pos)) begin
                lo_step[k] = '0;
            end else if (2'(k) == p_pos) begin
                lo_step[k] = r_local[k] + LOC_W'(1);
            end
        end
    end

    always_comb begin
        more = 1'b0;
        for (int k = 0; k < 4; k++) begin
            n_shell[k] = r_shell[k];
            n_local[k] = r_local[k];
            n_off[k]   = r_off[k];
        end
        if (i_accept) begin
            unique case (i_op)
                OP_SHELL: begin
                    more = !s_wrap;
                    for (int k = 0; k < 4; k++) begin
                        n_shell[k] = sh_step[k];
                        n_off[k]   = of_step[k];
                        n_local[k] = '0;
                    end
                end
                OP_PRIM: begin
                    more = !p_wrap;
                    for (int k = 0; k < 4; k++) begin
                        n_local[k] = lo_step[k];
                    end
                end
                OP_LOAD: more = 1'b0;
                OP_NONE: more = 1'b0;
                default: more = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_shell[k] <= '0;
                r_local[k] <= '0;
                r_off[k]   <= '0;
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                r_shell[k] <= n_shell[k];
                r_local[k] <= n_local[k];
                r_off[k]   <= n_off[k];
            end
        end
    end

    always_comb begin
        o_result.more = more;
        for (int k = 0; k < 4; k++) begin
            o_result.shell[k] = n_shell[k];
            o_result.prim[k]  = n_off[k] + OFF_W'(n_local[k]);
        end
    end

endmodule

[hdl/shell_quartet_index_sequencer.sv]
// ============================================================================
// shell_quartet_index_sequencer : four-index shell and primitive sequencer
// Loads per-shell primitive counts and steps a symmetry-unique shell quartet
// and a primitive odometer, one result per transfer.
// ============================================================================
// One item is taken every clock cycle unless o_stall is high, and its result
// is registered in r_out; a stalled result holds the input side only while
// the output register is full. The primitive count table is kept in four
// copies, one per quartet position, each read at the next shell index so the
// counts of the current quartet are always ready for the following item.
// A load of a count that belongs to a shell in the current quartet takes
// effect for the very next item. shell_count lives at byte address 0.
module shell_quartet_index_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,

    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_op,
    input  logic [sqis_pkg::SHELL_W-1:0]   i_shell,
    input  logic [sqis_pkg::CNT_W-1:0]     i_prim_count,

    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_more,
    output logic [sqis_pkg::SHELL_W-1:0]   o_shell_a,
    output logic [sqis_pkg::SHELL_W-1:0]   o_shell_b,
    output logic [sqis_pkg::SHELL_W-1:0]   o_shell_c,
    output logic [sqis_pkg::SHELL_W-1:0]   o_shell_d,
    output logic [sqis_pkg::OFF_W-1:0]     o_prim_a,
    output logic [sqis_pkg::OFF_W-1:0]     o_prim_b,
    output logic [sqis_pkg::OFF_W-1:0]     o_prim_c,
    output logic [sqis_pkg::OFF_W-1:0]     o_prim_d
);
    import sqis_pkg::*;

    logic [SCNT_W-1:0] r_shell_count;
    logic              r_out_valid;
    t_result           r_out;
    t_result           step_res;
    logic              accept;
    logic              cfg_wr;
    t_reg              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_sel)
            REG_SHELL_COUNT: prdata = 32'(r_shell_count);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shell_count <= SHELL_COUNT_RESET;
        end else if (cfg_wr && (reg_sel == REG_SHELL_COUNT)) begin
            r_shell_count <= pwdata[SCNT_W-1:0];
        end
    end

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    sqis_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (t_op'(i_op)),
        .i_shell      (i_shell),
        .i_prim_count (i_prim_count),
        .i_last       (last_shell(r_shell_count)),
        .o_result     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= step_res;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_more    = r_out.more;
    assign o_shell_a = r_out.shell[0];
    assign o_shell_b = r_out.shell[1];
    assign o_shell_c = r_out.shell[2];
    assign o_shell_d = r_out.shell[3];
    assign o_prim_a  = r_out.prim[0];
    assign o_prim_b  = r_out.prim[1];
    assign o_prim_c  = r_out.prim[2];
    assign o_prim_d  = r_out.prim[3];

`ifndef SYNTH
    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output register");

    a_load_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_op == OP_LOAD)) |=> (o_valid && !o_more))
        else $error("load transfer did not report with more low");

    a_quartet_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_shell_b <= o_shell_a) && (o_shell_c <= o_shell_a)))
        else $error("quartet left symmetry-unique order");
`endif

endmodule
